// ===== rtl/setq_pkg.sv =====
package setq_pkg;

	localparam int NUM_TIMERS_DEF = 32;
	localparam int TIME_BITS_DEF  = 32;
	localparam int TIME_IN_BITS   = 32;
	localparam int ID_BITS        = 5;
	// A tick pops at most this many timers; the rest wait for the next tick.
	localparam int MAX_POPS       = 32;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_ADJUST = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_TICK   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_DONE     = 2'd0,
		STAT_ACTIVE   = 2'd1,
		STAT_INACTIVE = 2'd2
	} status_t;

	typedef struct packed {
		action_t                   action;
		logic [ID_BITS-1:0]        timer_id;
		logic [TIME_IN_BITS-1:0]   expire_time;
		logic [TIME_IN_BITS-1:0]   current_time;
	} req_item_t;

	typedef struct packed {
		status_t                   status;
		logic                      expired_valid;
		logic [ID_BITS-1:0]        expired_id;
		logic                      last;
	} rsp_item_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2,
		CELL_POP    = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [ID_BITS-1:0] id;
	} cell_cmd_t;

	typedef struct packed {
		logic               valid;
		logic [ID_BITS-1:0] id;
	} cell_tag_t;

	// Flags that ripple from the head toward the tail.
	typedef struct packed {
		logic keep;
		logic found;
	} cell_flags_t;

endpackage

// ===== rtl/setq_cell.sv =====
module setq_cell #(
	parameter int TIME_BITS = setq_pkg::TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  setq_pkg::cell_cmd_t   cmd,
	input  logic [TIME_BITS-1:0]  cmd_expiry,
	input  setq_pkg::cell_tag_t   left_tag,
	input  logic [TIME_BITS-1:0]  left_expiry,
	input  setq_pkg::cell_flags_t left_flags,
	input  setq_pkg::cell_tag_t   right_tag,
	input  logic [TIME_BITS-1:0]  right_expiry,
	output setq_pkg::cell_tag_t   tag,
	output logic [TIME_BITS-1:0]  expiry,
	output setq_pkg::cell_flags_t flags
);
	import setq_pkg::*;

	cell_tag_t             tag_q, tag_d;
	logic [TIME_BITS-1:0]  expiry_q, expiry_d;

	// A new timer goes after this cell when this cell's expiry is not later.
	assign flags.keep  = tag_q.valid && !(cmd_expiry < expiry_q);
	assign flags.found = left_flags.found || (tag_q.valid && (tag_q.id == cmd.id));

	always_comb begin
		tag_d    = tag_q;
		expiry_d = expiry_q;
		unique case (cmd.op)
			CELL_INSERT: begin
				if (!flags.keep) begin
					if (left_flags.keep) begin
						tag_d.valid = 1'b1;
						tag_d.id    = cmd.id;
						expiry_d    = cmd_expiry;
					end else begin
						tag_d    = left_tag;
						expiry_d = left_expiry;
					end
				end
			end
			CELL_REMOVE: begin
				if (flags.found) begin
					tag_d    = right_tag;
					expiry_d = right_expiry;
				end
			end
			CELL_POP: begin
				tag_d    = right_tag;
				expiry_d = right_expiry;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q <= tag_d;
		end
	end

	always_ff @(posedge clk) begin
		expiry_q <= expiry_d;
	end

	assign tag    = tag_q;
	assign expiry = expiry_q;

endmodule

// ===== rtl/setq_chain.sv =====
module setq_chain #(
	parameter int NUM_TIMERS = setq_pkg::NUM_TIMERS_DEF,
	parameter int TIME_BITS  = setq_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  setq_pkg::cell_cmd_t  cmd,
	input  logic [TIME_BITS-1:0] cmd_expiry,
	output setq_pkg::cell_tag_t  head_tag,
	output logic [TIME_BITS-1:0] head_expiry,
	output logic                 second_valid,
	output logic [TIME_BITS-1:0] second_expiry
);
	import setq_pkg::*;

	cell_tag_t            tags    [NUM_TIMERS];
	logic [TIME_BITS-1:0] expiries[NUM_TIMERS];
	cell_flags_t          flags   [NUM_TIMERS];

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		cell_tag_t            l_tag, r_tag;
		logic [TIME_BITS-1:0] l_exp, r_exp;
		cell_flags_t          l_flags;

		if (i == 0) begin : g_head
			assign l_tag         = '0;
			assign l_exp         = '0;
			assign l_flags.keep  = 1'b1;
			assign l_flags.found = 1'b0;
		end else begin : g_link_l
			assign l_tag   = tags[i-1];
			assign l_exp   = expiries[i-1];
			assign l_flags = flags[i-1];
		end

		if (i == NUM_TIMERS - 1) begin : g_tail
			assign r_tag = '0;
			assign r_exp = '0;
		end else begin : g_link_r
			assign r_tag = tags[i+1];
			assign r_exp = expiries[i+1];
		end

		setq_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.cmd_expiry  (cmd_expiry),
			.left_tag    (l_tag),
			.left_expiry (l_exp),
			.left_flags  (l_flags),
			.right_tag   (r_tag),
			.right_expiry(r_exp),
			.tag         (tags[i]),
			.expiry      (expiries[i]),
			.flags       (flags[i])
		);
	end

	assign head_tag      = tags[0];
	assign head_expiry   = expiries[0];
	assign second_valid  = tags[1].valid;
	assign second_expiry = expiries[1];

endmodule

// ===== rtl/sorted_expiry_timer_queue_unit.sv =====
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_ready  setq_pkg::req_item_t (action, id, expiry, current time)
// rsp      out  rsp_valid/rsp_ready  setq_pkg::rsp_item_t (status, expired id, last)
//
// Add runs an insert step, delete a remove step, adjust a remove then an insert step, errors
// go straight to the reply step, and a tick runs one step per result (a popped timer or the single
// empty result); the control sequencer steps the cell row: one shift per cycle unless rsp stalls.
// Reset empties the row and marks every slot inactive at once; there is no clearing pass.
// A stalled rsp channel holds the sequencer in its insert, reply or tick step, leaving the row untouched.
module sorted_expiry_timer_queue_unit #(
	parameter int NUM_TIMERS = setq_pkg::NUM_TIMERS_DEF,
	parameter int TIME_BITS  = setq_pkg::TIME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  setq_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output setq_pkg::rsp_item_t rsp
);
	import setq_pkg::*;

	localparam int IDW      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int POP_BITS = $clog2(MAX_POPS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REMOVE,
		S_INSERT,
		S_REPLY,
		S_TICK
	} state_t;

	state_t                 state_q;
	action_t                act_q;
	status_t                status_q;
	logic [ID_BITS-1:0]     id_q;
	logic [TIME_BITS-1:0]   exp_q, now_q;
	logic [POP_BITS-1:0]    pop_cnt_q;
	logic [NUM_TIMERS-1:0]  slot_active_q;
	rsp_item_t              rsp_q;
	logic                   rsp_valid_q;

	logic [TIME_BITS-1:0]   exp_in, now_in;
	logic [IDW-1:0]         slot_idx, head_idx;
	logic                   in_range, slot_busy;
	logic                   out_free, head_expired, second_expired, pop_last;

	cell_cmd_t              cmd;
	cell_tag_t              head_tag;
	logic [TIME_BITS-1:0]   head_expiry, second_expiry;
	logic                   second_valid;

	// Times are kept in their low TIME_BITS bits.
	always_comb begin
		exp_in = '0;
		now_in = '0;
		for (int b = 0; b < TIME_BITS && b < TIME_IN_BITS; b++) begin
			exp_in[b] = req.expire_time[b];
			now_in[b] = req.current_time[b];
		end
	end

	assign in_range  = 32'(req.timer_id) < NUM_TIMERS;
	assign slot_idx  = IDW'(req.timer_id);
	assign slot_busy = slot_active_q[slot_idx];
	assign head_idx  = IDW'(head_tag.id);

	assign req_ready      = (state_q == S_IDLE);
	assign out_free       = !rsp_valid_q || rsp_ready;
	assign head_expired   = head_tag.valid && !(now_q < head_expiry);
	assign second_expired = second_valid && !(now_q < second_expiry);
	assign pop_last       = (pop_cnt_q == POP_BITS'(MAX_POPS - 1)) || !second_expired;

	always_comb begin
		cmd.op = CELL_HOLD;
		cmd.id = id_q;
		unique case (state_q)
			S_REMOVE: cmd.op = CELL_REMOVE;
			S_INSERT: if (out_free) cmd.op = CELL_INSERT;
			S_TICK:   if (out_free && head_expired) cmd.op = CELL_POP;
			default:  cmd.op = CELL_HOLD;
		endcase
	end

	setq_chain #(
		.NUM_TIMERS(NUM_TIMERS),
		.TIME_BITS (TIME_BITS)
	) u_chain (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cmd_expiry   (exp_q),
		.head_tag     (head_tag),
		.head_expiry  (head_expiry),
		.second_valid (second_valid),
		.second_expiry(second_expiry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			act_q         <= ACT_ADD;
			status_q      <= STAT_DONE;
			id_q          <= '0;
			exp_q         <= '0;
			now_q         <= '0;
			pop_cnt_q     <= '0;
			slot_active_q <= '0;
			rsp_q         <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						act_q     <= req.action;
						id_q      <= req.timer_id;
						exp_q     <= exp_in;
						now_q     <= now_in;
						pop_cnt_q <= '0;
						status_q  <= STAT_DONE;
						if (req.action == ACT_TICK) begin
							state_q <= S_TICK;
						end else if (!in_range) begin
							status_q <= STAT_INACTIVE;
							state_q  <= S_REPLY;
						end else if (req.action == ACT_ADD) begin
							if (slot_busy) begin
								status_q <= STAT_ACTIVE;
								state_q  <= S_REPLY;
							end else begin
								slot_active_q[slot_idx] <= 1'b1;
								state_q                 <= S_INSERT;
							end
						end else if (!slot_busy) begin
							status_q <= STAT_INACTIVE;
							state_q  <= S_REPLY;
						end else begin
							if (req.action == ACT_DELETE) begin
								slot_active_q[slot_idx] <= 1'b0;
							end
							state_q <= S_REMOVE;
						end
					end
				end
				S_REMOVE: begin
					state_q <= (act_q == ACT_ADJUST) ? S_INSERT : S_REPLY;
				end
				S_INSERT, S_REPLY: begin
					if (out_free) begin
						rsp_q.status        <= (state_q == S_REPLY) ? status_q : STAT_DONE;
						rsp_q.expired_valid <= 1'b0;
						rsp_q.expired_id    <= '0;
						rsp_q.last          <= 1'b1;
						rsp_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				S_TICK: begin
					if (out_free) begin
						rsp_q.status <= STAT_DONE;
						rsp_valid_q  <= 1'b1;
						if (head_expired) begin
							rsp_q.expired_valid     <= 1'b1;
							rsp_q.expired_id        <= head_tag.id;
							rsp_q.last              <= pop_last;
							slot_active_q[head_idx] <= 1'b0;
							pop_cnt_q               <= pop_cnt_q + 1'b1;
							if (pop_last) begin
								state_q <= S_IDLE;
							end
						end else begin
							// Nothing had expired: one empty result.
							rsp_q.expired_valid <= 1'b0;
							rsp_q.expired_id    <= '0;
							rsp_q.last          <= 1'b1;
							state_q             <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import setq_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int PHASE_ITEMS = 60;

	localparam rsp_item_t R_DONE     = '{STAT_DONE, 1'b0, 5'd0, 1'b1};
	localparam rsp_item_t R_ACTIVE   = '{STAT_ACTIVE, 1'b0, 5'd0, 1'b1};
	localparam rsp_item_t R_INACTIVE = '{STAT_INACTIVE, 1'b0, 5'd0, 1'b1};

	typedef struct packed {
		action_t           act;
		logic [4:0]        id;
		logic [31:0]       exp_t;
		logic [31:0]       cur_t;
		logic              has_want;
		rsp_item_t         want;
	} dir_row_t;

	localparam int NUM_ROWS = 20;
	localparam dir_row_t DIR_ROWS [0:NUM_ROWS-1] = '{
		'{ACT_TICK,   5'd0,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, R_DONE},
		'{ACT_ADJUST, 5'd3,  32'd5,         32'h0000_0000, 1'b1, R_INACTIVE},
		'{ACT_DELETE, 5'd31, 32'd0,         32'hFFFF_FFFF, 1'b1, R_INACTIVE},
		'{ACT_ADD,    5'd0,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, R_DONE},
		'{ACT_ADD,    5'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, R_ACTIVE},
		'{ACT_ADD,    5'd31, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, R_DONE},
		'{ACT_ADD,    5'd5,  32'd100,       32'd0,         1'b1, R_DONE},
		'{ACT_ADD,    5'd6,  32'd100,       32'd0,         1'b1, R_DONE},
		'{ACT_ADD,    5'd7,  32'd100,       32'd0,         1'b1, R_DONE},
		'{ACT_ADJUST, 5'd5,  32'd100,       32'd0,         1'b1, R_DONE},
		'{ACT_ADJUST, 5'd0,  32'd50,        32'd0,         1'b1, R_DONE},
		'{ACT_TICK,   5'd0,  32'd0,         32'd99,        1'b0, R_DONE},
		'{ACT_DELETE, 5'd6,  32'd0,         32'd0,         1'b1, R_DONE},
		'{ACT_DELETE, 5'd6,  32'd0,         32'd0,         1'b1, R_INACTIVE},
		'{ACT_ADD,    5'd6,  32'd200,       32'd0,         1'b1, R_DONE},
		'{ACT_TICK,   5'd0,  32'd0,         32'd100,       1'b0, R_DONE},
		'{ACT_ADJUST, 5'd6,  32'hFFFF_FFFF, 32'd0,         1'b1, R_DONE},
		'{ACT_TICK,   5'd0,  32'd0,         32'hFFFF_FFFE, 1'b0, R_DONE},
		'{ACT_TICK,   5'd0,  32'd0,         32'hFFFF_FFFF, 1'b0, R_DONE},
		'{ACT_ADD,    5'd12, 32'h0000_0000, 32'd0,         1'b1, R_DONE}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_item_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_item_t rsp;

	// Predicted state of the timer list.
	logic [TIME_IN_BITS-1:0] exp_of [NUM_TIMERS_DEF];
	logic live [NUM_TIMERS_DEF] = '{default: 1'b0};
	logic [ID_BITS-1:0] order_ids [NUM_TIMERS_DEF];
	int live_cnt = 0;

	rsp_item_t expected_rsp [$];
	rsp_item_t want_rsp;

	logic [31:0] clock_now;
	logic calm = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	int unsigned mismatch_count = 0;
	int unsigned n_items = 0;
	int unsigned n_results = 0;
	int unsigned n_pop_ticks = 0;
	int unsigned max_pops = 0;

	sorted_expiry_timer_queue_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [31:0] pick_expiry();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return clock_now + $urandom_range(0, 24);
		end else if (r < 92) begin
			return $urandom;
		end else if (r < 96) begin
			return 32'h0000_0000;
		end
		return 32'hFFFF_FFFF;
	endfunction

	// Stable insert: the id goes after every timer whose expiry is not later.
	task automatic place_id(input logic [ID_BITS-1:0] id);
		int pos;
		pos = 0;
		if (live_cnt >= NUM_TIMERS_DEF) begin
			return;
		end
		while (pos < live_cnt && !(exp_of[id] < exp_of[order_ids[pos]])) begin
			pos++;
		end
		for (int i = live_cnt; i > pos; i--) begin
			order_ids[i] = order_ids[i-1];
		end
		order_ids[pos] = id;
		live_cnt++;
	endtask

	task automatic drop_id(input logic [ID_BITS-1:0] id);
		int pos;
		pos = 0;
		while (pos < live_cnt && order_ids[pos] != id) begin
			pos++;
		end
		if (pos >= live_cnt) begin
			return;
		end
		for (int i = pos; i + 1 < live_cnt; i++) begin
			order_ids[i] = order_ids[i+1];
		end
		live_cnt--;
	endtask

	task automatic timer_list_step(input req_item_t it, input logic has_want,
			input rsp_item_t want);
		rsp_item_t r;
		logic [ID_BITS-1:0] head;
		logic more;
		int pops;
		r = R_DONE;
		pops = 0;
		if (it.action == ACT_TICK) begin
			more = live_cnt > 0 && it.current_time >= exp_of[order_ids[0]];
			while (more) begin
				head = order_ids[0];
				drop_id(head);
				live[head] = 1'b0;
				pops++;
				more = pops < MAX_POPS && live_cnt > 0
					&& it.current_time >= exp_of[order_ids[0]];
				expected_rsp.push_back('{STAT_DONE, 1'b1, head, !more});
			end
			if (pops != 0) begin
				n_pop_ticks++;
				if (pops > max_pops) begin
					max_pops = pops;
				end
				return;
			end
		end else if (it.action == ACT_ADD) begin
			if (live[it.timer_id]) begin
				r = R_ACTIVE;
			end else begin
				exp_of[it.timer_id] = it.expire_time;
				live[it.timer_id] = 1'b1;
				place_id(it.timer_id);
			end
		end else if (!live[it.timer_id]) begin
			r = R_INACTIVE;
		end else begin
			drop_id(it.timer_id);
			if (it.action == ACT_ADJUST) begin
				exp_of[it.timer_id] = it.expire_time;
				place_id(it.timer_id);
			end else begin
				live[it.timer_id] = 1'b0;
			end
		end
		expected_rsp.push_back(has_want ? want : r);
	endtask

	// Valid goes low only when a gap follows, so a back-to-back transaction keeps it high.
	task automatic send_item(input req_item_t it, input logic has_want, input rsp_item_t want);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		timer_list_step(it, has_want, want);
		n_items++;
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ready <= 1'b1;
			if (!calm && $urandom_range(0, 99) < 30) begin
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				n_results++;
				if (expected_rsp.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Unexpected result transaction: status %0d valid %0d id %0d last %0d",
							rsp.status, rsp.expired_valid, rsp.expired_id, rsp.last);
					end
				end else begin
					want_rsp = expected_rsp.pop_front();
					if (rsp.status !== want_rsp.status
							|| rsp.expired_valid !== want_rsp.expired_valid
							|| rsp.expired_id !== want_rsp.expired_id
							|| rsp.last !== want_rsp.last) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("Result %0d differs: expected status %0d valid %0d id %0d last %0d, got status %0d valid %0d id %0d last %0d",
								n_results, want_rsp.status, want_rsp.expired_valid,
								want_rsp.expired_id, want_rsp.last, rsp.status,
								rsp.expired_valid, rsp.expired_id, rsp.last);
						end
					end
				end
			end
			if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		req_item_t it;
		int r;
		int tries;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < NUM_ROWS; k++) begin
			it.action = DIR_ROWS[k].act;
			it.timer_id = DIR_ROWS[k].id;
			it.expire_time = DIR_ROWS[k].exp_t;
			it.current_time = DIR_ROWS[k].cur_t;
			send_item(it, DIR_ROWS[k].has_want, DIR_ROWS[k].want);
		end

		clock_now = $urandom_range(0, 1000);
		for (int ph = 0; ph < 6; ph++) begin
			calm = (ph == 4);
			// The last phase starts the time base just below the 32-bit wrap.
			if (ph == 5) begin
				clock_now = 32'hFFFF_FF00;
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				it.timer_id = ID_BITS'($urandom);
				it.expire_time = $urandom;
				it.current_time = $urandom;
				if (r < 32) begin
					it.action = ACT_ADD;
					if ($urandom_range(0, 9) < 8) begin
						for (tries = 0; tries < 8 && live[it.timer_id]; tries++) begin
							it.timer_id = ID_BITS'($urandom);
						end
					end
					it.expire_time = pick_expiry();
				end else if (r < 66) begin
					it.action = (r < 52) ? ACT_ADJUST : ACT_DELETE;
					if (live_cnt != 0 && $urandom_range(0, 9) < 8) begin
						it.timer_id = order_ids[$urandom_range(0, live_cnt - 1)];
					end
					if (it.action == ACT_ADJUST) begin
						it.expire_time = pick_expiry();
					end
				end else begin
					it.action = ACT_TICK;
					clock_now = clock_now + $urandom_range(0, 10);
					r = $urandom_range(0, 99);
					if (r < 85) begin
						it.current_time = clock_now;
					end else if (r > 95) begin
						it.current_time = 32'hFFFF_FFFF;
					end
				end
				send_item(it, 1'b0, R_DONE);
			end

			// Fill every free slot with near-equal expiries, then expire the lot in one tick.
			if (ph % 2 == 1) begin
				for (int k = 0; k < NUM_TIMERS_DEF; k++) begin
					if (!live[k]) begin
						it.action = ACT_ADD;
						it.timer_id = k[ID_BITS-1:0];
						it.expire_time = clock_now + $urandom_range(0, 3);
						it.current_time = $urandom;
						send_item(it, 1'b0, R_DONE);
					end
				end
				clock_now = clock_now + 3;
				it.action = ACT_TICK;
				it.timer_id = ID_BITS'($urandom);
				it.expire_time = $urandom;
				it.current_time = clock_now;
				send_item(it, 1'b0, R_DONE);
			end

			if (ph == 2) begin
				req_valid <= 1'b0;
				while (expected_rsp.size() != 0) begin
					@(posedge clk);
				end
			end
		end

		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d request transactions and checked %0d result transactions.",
			n_items, n_results);
		$display("%0d ticks expired timers, at most %0d in a single tick.",
			n_pop_ticks, max_pops);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
